/* rtl/ple_pkg.sv */
// Shared types and constants for the positional list engine.
package ple_pkg;

  localparam int unsigned DEPTH_DEF      = 64;
  localparam int unsigned VALUE_BITS_DEF = 64;
  localparam int unsigned POS_W          = 8;
  localparam int unsigned LENGTH_W       = 7;
  localparam int unsigned GROUP_SIZE     = 8;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_DELETE  = 2'd1,
    OP_GET     = 2'd2,
    OP_REVERSE = 2'd3
  } op_e;

  // Broadcast command from the control logic to every cell.
  typedef struct packed {
    logic ins;
    logic del;
    logic get;
  } cmd_t;

endpackage

/* rtl/positional_list_engine.sv */
// Top level of the positional list engine: control, cell row and result stages.
//
//   channel | direction | handshake               | payload
//   in      | sink      | in_valid_i / in_stall_o  | operation_i, position_i, value_i
//   out     | source    | out_valid_o / out_stall_i| read_value_o, length_o, is_empty_o,
//           |           |                          | full_reject_o
//
// One transaction per cycle while in_stall_o is low; the cell row updates at the accepting edge.
// A result passes through the pending register and then the output register to out_valid_o.
// A pending result and the output register let one transaction wait on each side.
// Reverse toggles an orientation flag when more than one entry is held, so no entry moves.
// Reset clears the count, orientation and valid flags; entries are not cleared.
module positional_list_engine import ple_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            operation_i,
  input  logic [POS_W-1:0]      position_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [VALUE_BITS-1:0] read_value_o,
  output logic [LENGTH_W-1:0]   length_o,
  output logic                  is_empty_o,
  output logic                  full_reject_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] FullCount = CW'(DEPTH);

  logic [CW-1:0]         count_q, count_d;
  logic                  dir_q, dir_d;
  logic                  accept, p_move;
  logic                  p_valid_q;
  logic [LENGTH_W-1:0]   p_len_q;
  logic                  p_empty_q, p_rej_q;
  logic                  out_valid_q;
  logic [VALUE_BITS-1:0] out_read_q;
  logic [LENGTH_W-1:0]   out_len_q;
  logic                  out_empty_q, out_rej_q;
  logic                  reject;
  op_e                   op;
  cmd_t                  cmd;
  logic [IW-1:0]         slot_w, cnt_w, s_ins, s_get, pos;
  logic [VALUE_BITS-1:0] tree_read;

  logic [DEPTH-1:0][VALUE_BITS-1:0] entry, hit;

  assign op     = op_e'(operation_i);
  assign p_move = p_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = p_valid_q && !p_move;
  assign accept = in_valid_i && !in_stall_o;

  assign slot_w = (position_i <= POS_W'(1)) ? '0 : IW'(position_i - POS_W'(1));
  assign cnt_w  = IW'(count_q);
  assign s_ins  = (slot_w > cnt_w) ? cnt_w : slot_w;
  assign s_get  = (slot_w >= cnt_w) ? cnt_w - IW'(1) : slot_w;

  always_comb begin
    cmd     = '0;
    pos     = '0;
    reject  = 1'b0;
    count_d = count_q;
    dir_d   = dir_q;
    if (accept) begin
      unique case (op)
        OP_INSERT: begin
          if (count_q == FullCount) begin
            reject = 1'b1;
          end else begin
            cmd.ins = 1'b1;
            pos     = dir_q ? cnt_w - s_ins : s_ins;
            count_d = count_q + CW'(1);
          end
        end
        OP_DELETE: begin
          if (slot_w < cnt_w) begin
            cmd.del = 1'b1;
            pos     = dir_q ? cnt_w - IW'(1) - slot_w : slot_w;
            count_d = count_q - CW'(1);
          end
        end
        OP_GET: begin
          if (count_q != '0) begin
            cmd.get = 1'b1;
            pos     = dir_q ? cnt_w - IW'(1) - s_get : s_get;
          end
        end
        OP_REVERSE: begin
          if (count_q > CW'(1)) dir_d = !dir_q;
        end
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [VALUE_BITS-1:0] lower, upper;
    if (k == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = entry[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign upper = entry[k];
    end else begin : g_mid_hi
      assign upper = entry[k+1];
    end
    ple_cell #(
      .VALUE_BITS (VALUE_BITS),
      .IDX_W      (IW),
      .IDX        (k)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (pos),
      .value_i (value_i),
      .lower_i (lower),
      .upper_i (upper),
      .entry_o (entry[k]),
      .hit_o   (hit[k])
    );
  end

  ple_read_tree #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_read_tree (
    .clk_i  (clk_i),
    .load_i (accept),
    .hit_i  (hit),
    .read_o (tree_read)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dir_q       <= 1'b0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      dir_q   <= dir_d;
      if (accept) p_valid_q <= 1'b1;
      else if (p_move) p_valid_q <= 1'b0;
      if (p_move) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_len_q   <= LENGTH_W'(count_d);
      p_empty_q <= (count_d == '0);
      p_rej_q   <= reject;
    end
    if (p_move) begin
      out_read_q  <= tree_read;
      out_len_q   <= p_len_q;
      out_empty_q <= p_empty_q;
      out_rej_q   <= p_rej_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = out_read_q;
  assign length_o      = out_len_q;
  assign is_empty_o    = out_empty_q;
  assign full_reject_o = out_rej_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("entry count above depth");

  a_reject_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q && p_rej_q |-> count_q == FullCount)
    else $error("insert refused while list not full");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op == OP_INSERT && count_q != FullCount |=> count_q == $past(count_q) + CW'(1))
    else $error("accepted insert did not grow the list");

endmodule

/* rtl/ple_cell.sv */
// One list cell: holds an entry and shifts to or from its neighbours.
module ple_cell import ple_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned IDX_W      = 8,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk_i,
  input  cmd_t                  cmd_i,
  input  logic [IDX_W-1:0]      pos_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [VALUE_BITS-1:0] lower_i,
  input  logic [VALUE_BITS-1:0] upper_i,
  output logic [VALUE_BITS-1:0] entry_o,
  output logic [VALUE_BITS-1:0] hit_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic [VALUE_BITS-1:0] entry_q, entry_d;
  logic                  at_pos, above_pos;

  assign at_pos    = (pos_i == MyIdx);
  assign above_pos = (MyIdx > pos_i);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (above_pos) entry_d = lower_i;
      else if (at_pos) entry_d = value_i;
    end else if (cmd_i.del) begin
      if (above_pos || at_pos) entry_d = upper_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign hit_o   = entry_q & {VALUE_BITS{cmd_i.get && at_pos}};

endmodule

/* rtl/ple_read_tree.sv */
// Registered OR tree that gathers the single selected entry of a get.
module ple_read_tree import ple_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             load_i,
  input  logic [DEPTH-1:0][VALUE_BITS-1:0] hit_i,
  output logic [VALUE_BITS-1:0]            read_o
);

  localparam int unsigned NGroups = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [NGroups-1:0][VALUE_BITS-1:0] grp_q, grp_d;

  always_comb begin
    for (int g = 0; g < NGroups; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (g * GROUP_SIZE + j < DEPTH) grp_d[g] = grp_d[g] | hit_i[g * GROUP_SIZE + j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) grp_q <= grp_d;
  end

  always_comb begin
    read_o = '0;
    for (int g = 0; g < NGroups; g++) begin
      read_o = read_o | grp_q[g];
    end
  end

endmodule
